// ----- sv/rfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the ring fork arbiter
// Client state codes, operation and status codes, the controller to datapath
// command and status bundles, and ring neighbor helpers.
// ----------------------------------------------------------------------------
package rfa_pkg;

   // Field widths fixed by the item format
   localparam int CLIENT_W = 4;
   localparam int COUNT_W  = 5;

   // Count value after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // Per-client state
   typedef enum logic [1:0] {
      ST_THINKING = 2'd0,
      ST_HUNGRY   = 2'd1,
      ST_EATING   = 2'd2
   } client_state_type;

   // Operation codes
   typedef enum logic {
      OP_TAKE = 1'b0,
      OP_PUT  = 1'b1
   } op_type;

   // Result status codes
   typedef enum logic {
      STATUS_OK        = 1'b0,
      STATUS_OUT_RANGE = 1'b1
   } status_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;     // capture the input item
      logic mark;     // write the issuing client's new state
      logic grant1;   // try the first subject and emit its result
      logic grant2;   // try the previous neighbor and emit its result
      logic error;    // emit the out-of-range result
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic in_range;
      logic is_put;
      logic out_free;
   } dp_status_type;

   // Next client around the ring of n clients, c < n
   function automatic logic [COUNT_W-1:0] ring_next(input logic [COUNT_W-1:0] c,
                                                    input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] inc;
      inc = c + 5'd1;
      return (inc == n) ? '0 : inc;
   endfunction

   // Previous client around the ring of n clients, c < n
   function automatic logic [COUNT_W-1:0] ring_prev(input logic [COUNT_W-1:0] c,
                                                    input logic [COUNT_W-1:0] n);
      return (c == '0) ? (n - 5'd1) : (c - 5'd1);
   endfunction

endpackage
`default_nettype wire

// ----- sv/rfa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_req_if: request channel
// Valid/ready channel carrying one take or put operation per transfer.
// ----------------------------------------------------------------------------
interface rfa_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [3:0] client;

   modport source (output valid, output operation, output client, input ready);
   modport sink   (input valid, input operation, input client, output ready);
endinterface
`default_nettype wire

// ----- sv/rfa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_rsp_if: response channel
// Valid/ready channel carrying one grant decision per transfer.
// ----------------------------------------------------------------------------
interface rfa_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] subject;
   logic       granted;
   logic       status;
   logic       last;

   modport source (output valid, output subject, output granted, output status,
                   output last, input ready);
   modport sink   (input valid, input subject, input granted, input status,
                   input last, output ready);
endinterface
`default_nettype wire

// ----- sv/rfa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_datapath: client state table, grant check and response register
// Holds the client count, the per-client states and the captured item, runs
// one grant check per command and drives the response output register.
// ----------------------------------------------------------------------------
module rfa_datapath #(
   parameter int MAX_CLIENTS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_en,
   input  wire logic [rfa_pkg::COUNT_W-1:0]  csr_write_data,
   input  wire logic                         item_operation,
   input  wire logic [rfa_pkg::CLIENT_W-1:0] item_client,
   input  wire rfa_pkg::ctl_cmd_type         cmd,
   output rfa_pkg::dp_status_type            sts,
   input  wire logic                         rsp_ready,
   output logic                              rsp_valid,
   output logic [rfa_pkg::CLIENT_W-1:0]      rsp_subject,
   output logic                              rsp_granted,
   output logic                              rsp_status,
   output logic                              rsp_last
);
   import rfa_pkg::*;

   // The 5-bit count never reaches beyond 31 clients
   localparam int DEPTH = (MAX_CLIENTS < 31) ? MAX_CLIENTS : 31;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(DEPTH);

   logic [COUNT_W-1:0]  count_ff;
   op_type              op_ff;
   logic [CLIENT_W-1:0] client_ff;
   client_state_type    state_ff [DEPTH];

   logic                rsp_valid_ff;
   logic [CLIENT_W-1:0] subject_ff, subject_in;
   logic                granted_ff, granted_in;
   status_type          status_ff, status_in;
   logic                last_ff, last_in;

   logic [COUNT_W-1:0] ring_n;
   logic [COUNT_W-1:0] c5, c_nxt, c_prv, target, t_nxt, t_prv;
   logic [IDX_W-1:0]   c_idx, tgt_idx, tn_idx, tp_idx;
   logic               grant_ok;
   logic               push;

   // Effective ring size: zero acts as one, clamp to the table depth
   always_comb begin
      if (count_ff == '0) begin
         ring_n = 5'd1;
      end else if (count_ff > CAP) begin
         ring_n = CAP;
      end else begin
         ring_n = count_ff;
      end
   end

   // Neighbors of the issuing client and of the subject under test
   always_comb begin
      c5     = {1'b0, client_ff};
      c_nxt  = ring_next(c5, ring_n);
      c_prv  = ring_prev(c5, ring_n);
      if (cmd.grant2) begin
         target = c_prv;
      end else if (op_ff == OP_PUT) begin
         target = c_nxt;
      end else begin
         target = c5;
      end
      t_nxt   = ring_next(target, ring_n);
      t_prv   = ring_prev(target, ring_n);
      c_idx   = c5[IDX_W-1:0];
      tgt_idx = target[IDX_W-1:0];
      tn_idx  = t_nxt[IDX_W-1:0];
      tp_idx  = t_prv[IDX_W-1:0];
   end

   // Grant when hungry and neither neighbor is eating
   assign grant_ok = (state_ff[tgt_idx] == ST_HUNGRY) &&
                     (state_ff[tn_idx] != ST_EATING) &&
                     (state_ff[tp_idx] != ST_EATING);

   assign sts.in_range = (c5 < ring_n);
   assign sts.is_put   = (op_ff == OP_PUT);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign push = cmd.grant1 || cmd.grant2 || cmd.error;

   // Next response payload
   always_comb begin
      subject_in = subject_ff;
      granted_in = granted_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      if (cmd.error) begin
         subject_in = client_ff;
         granted_in = 1'b0;
         status_in  = STATUS_OUT_RANGE;
         last_in    = 1'b1;
      end else if (cmd.grant1 || cmd.grant2) begin
         subject_in = target[CLIENT_W-1:0];
         granted_in = grant_ok;
         status_in  = STATUS_OK;
         last_in    = cmd.grant2 || (op_ff == OP_TAKE);
      end
   end

   // Control state: count, client table, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            state_ff[i] <= ST_THINKING;
         end
      end else begin
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.mark) begin
            state_ff[c_idx] <= (op_ff == OP_PUT) ? ST_THINKING : ST_HUNGRY;
         end else if ((cmd.grant1 || cmd.grant2) && grant_ok) begin
            state_ff[tgt_idx] <= ST_EATING;
         end
      end
   end

   // Payload registers: captured item and response fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(item_operation);
         client_ff <= item_client;
      end
      if (push) begin
         subject_ff <= subject_in;
         granted_ff <= granted_in;
         status_ff  <= status_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_subject = subject_ff;
   assign rsp_granted = granted_ff;
   assign rsp_status  = status_ff;
   assign rsp_last    = last_ff;

   // A granted subject is eating right after the check
   a_grant_eats: assert property (@(posedge clock) disable iff (reset)
      (cmd.grant1 || cmd.grant2) && grant_ok |=> state_ff[$past(tgt_idx)] == ST_EATING)
      else $error("granted subject not eating");

   // An out-of-range result never carries a grant
   a_error_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_OUT_RANGE |-> !granted_ff)
      else $error("out-of-range result granted");

   // A pending response holds while the sink stalls and nothing new is pushed
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("pending response dropped");

endmodule
`default_nettype wire

// ----- sv/rfa_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_controller: operation sequencer
// Accepts one item at a time: mark, first grant check and, for a release,
// second grant check, or an error result; waits on the response register.
// ----------------------------------------------------------------------------
module rfa_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rfa_pkg::dp_status_type sts,
   output rfa_pkg::ctl_cmd_type        cmd
);
   import rfa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MARK,
      S_GRANT1,
      S_GRANT2
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   // Decode commands and next state
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (!sts.in_range) begin
               if (sts.out_free) begin
                  cmd.error = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               cmd.mark = 1'b1;
               state_in = S_GRANT1;
            end
         end
         S_GRANT1: begin
            if (sts.out_free) begin
               cmd.grant1 = 1'b1;
               state_in   = sts.is_put ? S_GRANT2 : S_IDLE;
            end
         end
         S_GRANT2: begin
            if (sts.out_free) begin
               cmd.grant2 = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Never emit a result into a full response register
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.grant1 || cmd.grant2 || cmd.error) |-> sts.out_free)
      else $error("result pushed into full response register");

   // Second grant check only follows a release
   a_grant2_put: assert property (@(posedge clock) disable iff (reset)
      cmd.grant2 |-> sts.is_put && sts.in_range)
      else $error("second grant check on a request");

   // Item transfer closes the input until the sequence ends
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

endmodule
`default_nettype wire

// ----- sv/ring_fork_arbiter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Timing: a result is loaded at the sequencer's first grant check, or at the
//   mark step for an out-of-range client; a release's second result is
//   loaded at the edge that transfers the first.
// Items: a new item is taken only once the sequencer is back in idle, after
//   the mark and grant steps of the last item, which wait on the response register.
// Reset: synchronous; all clients thinking, client count 16, no result held.
// ----------------------------------------------------------------------------
// ring_fork_arbiter: ring arbiter top level
// Grants clients that share a resource with each ring neighbor; a controller
// sequences each operation over the client state datapath.
// ----------------------------------------------------------------------------
module ring_fork_arbiter #(
   parameter int MAX_CLIENTS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_en,
   input  wire logic [rfa_pkg::COUNT_W-1:0] csr_write_data,
   rfa_req_if.sink                          req,
   rfa_rsp_if.source                        rsp
);
   import rfa_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type sts;

   rfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfa_datapath #(
      .MAX_CLIENTS (MAX_CLIENTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .item_operation (req.operation),
      .item_client    (req.client),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_subject    (rsp.subject),
      .rsp_granted    (rsp.granted),
      .rsp_status     (rsp.status),
      .rsp_last       (rsp.last)
   );

endmodule
`default_nettype wire
